// File: hdl/fmva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmva_pkg
// Shared types, constants and float helpers for the float matrix-vector
// multiply-accumulate block.
// ----------------------------------------------------------------------------
package fmva_pkg;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_MATRIX = 1'b1;

   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  vector_index;
      logic [31:0] element_bits;
      logic [31:0] seed_bits;
   } req_type_type;

   typedef struct packed {
      logic [15:0] row_number;
      logic [31:0] sum_bits;
      logic        last_row;
   } rsp_type;

   // product stage result handed to the add stage
   typedef struct packed {
      logic        special;
      logic [31:0] special_bits;
      logic        sp;
      logic        pzero;
      logic [47:0] mp;
      logic signed [10:0] ep;
   } prod_type;

   // round a nonzero 64-bit magnitude r*2^e, r already has bit 63 set
   function automatic logic [31:0] round_pack(input logic s, input logic [63:0] r,
                                              input logic signed [11:0] e);
      logic signed [11:0] be;
      logic [6:0]  sh;
      logic [63:0] kept, rem, half, v;
      logic [31:0] res;
      begin
         be = e + 12'sd190;
         if (be >= 12'sd1) sh = 7'd40;
         else if (be < -12'sd23) sh = 7'd65;
         else sh = 7'(12'sd41 - be);
         kept = '0; rem = '0; half = '0; v = '0;
         if (sh > 7'd64) begin
            res = {s, 31'd0};
         end else if (sh == 7'd64) begin
            res = {s, 30'd0, (r > 64'h8000_0000_0000_0000)};
         end else begin
            kept = r >> sh;
            rem  = r & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 7'd1);
            if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
            if (be >= 12'sd1) begin
               // biased exponent above the hidden bit, carry from rounding ripples in
               v = ({52'd0, 12'(be - 12'sd1)} << 23) + kept;
               if (v >= {32'd0, INF_BITS}) res = {s, INF_BITS[30:0]};
               else res = {s, v[30:0]};
            end else begin
               res = {s, kept[30:0]};
            end
         end
         return res;
      end
   endfunction

   // leading zero count of a 64-bit word
   function automatic logic [6:0] lzc64(input logic [63:0] x);
      logic [6:0] n;
      logic       hit;
      begin
         n = 7'd64; hit = 1'b0;
         for (int i = 63; i >= 0; i--) begin
            if (!hit && x[i]) begin
               n = 7'(63 - i); hit = 1'b1;
            end
         end
         return n;
      end
   endfunction

endpackage

// File: hdl/float_matvec_accumulate.sv
`timescale 1ns / 1ps
// rsp_valid is raised by the response register once a row-ending matrix transaction has
// passed the multiply, align/add and normalize/round stages. Throughput: one vector load per
// cycle while idle; a matrix element is taken only after the last has looped through these
// stages and the accumulator; a row end waits in the round stage while a result is unread.
// Reset: synchronous, active high; counts return to 1, positions and accumulator to 0.
// The vector store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// float_matvec_accumulate
// Streams row-major matrix elements against a stored vector and accumulates
// each row with a single-precision fused multiply-add.
// ----------------------------------------------------------------------------
module float_matvec_accumulate
   import fmva_pkg::*;
#(
   parameter int MAX_COLS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  logic         csr_write,
   input  logic         csr_index,
   input  logic [15:0]  csr_data
);

   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CW = $clog2(MAX_COLS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADD, ST_DONE} stage_type;

   stage_type   state_ff, state_in;
   logic [15:0] row_count_ff;
   logic [8:0]  col_count_ff;
   logic [CW-1:0] col_pos_ff, col_pos_in;
   logic [15:0] row_pos_ff, row_pos_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] elem_ff;
   logic        oob_ff;
   prod_type    prod_ff, prod_in;
   logic [63:0] rnd_sum_ff, rnd_sum_in;
   logic        rnd_sx_ff, rnd_sx_in;
   logic signed [11:0] rnd_e_ff, rnd_e_in;
   logic        rnd_byp_ff, rnd_byp_in;
   logic [31:0] rnd_byp_bits_ff, rnd_byp_bits_in;
   logic [31:0] fma_res;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic        emit;
   logic        row_end;

   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   ram_rdata;
   logic          ram_we;

   logic accept;
   assign accept = req_valid && req_ready;

   // vector store
   assign ram_we    = accept && req_data.req_type == REQ_LOAD
                      && ({24'd0, req_data.vector_index} < 32'(MAX_COLS));
   assign ram_waddr = AW'(req_data.vector_index);
   assign ram_raddr = AW'(col_pos_ff);

   fmva_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data.element_bits),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // any transaction only while no matrix item is in flight, keeps store reads coherent
   assign req_ready = (state_ff == ST_IDLE);

   // effective counts
   logic [CW:0]  cols_eff;
   logic [15:0]  rows_eff;
   always_comb begin
      if (col_count_ff == 9'd0) cols_eff = (CW+1)'(1);
      else if ({23'd0, col_count_ff} > 32'(MAX_COLS)) cols_eff = (CW+1)'(MAX_COLS);
      else cols_eff = (CW+1)'(col_count_ff);
      rows_eff = (row_count_ff == 16'd0) ? 16'd1 : row_count_ff;
   end

   // product stage: multiply and specials
   logic [31:0] va, vb, vc;
   always_comb begin
      logic ea_z, eb_z, nan_a, nan_b, nan_c, inf_a, inf_b, inf_c;
      va = elem_ff;
      vb = oob_ff ? 32'd0 : ram_rdata;
      vc = acc_ff;
      ea_z = va[30:23] == 8'd0; eb_z = vb[30:23] == 8'd0;
      nan_a = va[30:23] == 8'hFF && va[22:0] != 0;
      nan_b = vb[30:23] == 8'hFF && vb[22:0] != 0;
      nan_c = vc[30:23] == 8'hFF && vc[22:0] != 0;
      inf_a = va[30:23] == 8'hFF; inf_b = vb[30:23] == 8'hFF;
      inf_c = vc[30:23] == 8'hFF;
      prod_in.sp = va[31] ^ vb[31];
      prod_in.special = 1'b1;
      prod_in.special_bits = QNAN_BITS;
      if (nan_a || nan_b || nan_c) prod_in.special_bits = QNAN_BITS;
      else if (inf_a || inf_b) begin
         if ((inf_a && vb[30:0] == 0) || (inf_b && va[30:0] == 0))
            prod_in.special_bits = QNAN_BITS;
         else if (inf_c && vc[31] != prod_in.sp) prod_in.special_bits = QNAN_BITS;
         else prod_in.special_bits = {prod_in.sp, INF_BITS[30:0]};
      end else if (inf_c) prod_in.special_bits = vc;
      else prod_in.special = 1'b0;
      prod_in.mp = {24'd0, ~ea_z, va[22:0]} * {24'd0, ~eb_z, vb[22:0]};
      prod_in.ep = 11'(ea_z ? 1 : va[30:23]) + 11'(eb_z ? 1 : vb[30:23]) - 11'sd300;
      prod_in.pzero = prod_in.mp == 48'd0;
   end

   // add stage: align and add, zero and special results bypass rounding
   always_comb begin
      logic [63:0] x, y, mc64, mp64;
      logic signed [11:0] ep, ec, ex, ey, d;
      logic sx, sy, sc;
      logic [6:0] lz;
      sc = acc_ff[31];
      mc64 = {40'd0, acc_ff[30:23] != 0, acc_ff[22:0]};
      ec = 12'(acc_ff[30:23] == 0 ? 1 : acc_ff[30:23]) - 12'sd150;
      mp64 = {16'd0, prod_ff.mp};
      ep = 12'(prod_ff.ep);
      x = '0; y = '0; ex = '0; ey = '0; sx = 1'b0; sy = 1'b0; d = '0; lz = '0;
      rnd_byp_in = 1'b1; rnd_byp_bits_in = 32'd0;
      rnd_sum_in = '0; rnd_sx_in = 1'b0; rnd_e_in = '0;
      if (prod_ff.special) rnd_byp_bits_in = prod_ff.special_bits;
      else if (prod_ff.pzero) begin
         if (mc64 == 0) rnd_byp_bits_in = {prod_ff.sp & sc, 31'd0};
         else rnd_byp_bits_in = acc_ff;
      end else if (mc64 == 0) begin
         rnd_byp_in = 1'b0;
         rnd_sum_in = mp64; rnd_sx_in = prod_ff.sp; rnd_e_in = ep;
      end else begin
         lz = lzc64(mp64); mp64 = mp64 << lz; ep = ep - 12'(lz) + 12'sd2;
         mp64 = mp64 >> 2;
         lz = lzc64(mc64); mc64 = mc64 << lz; ec = ec - 12'(lz) + 12'sd2;
         mc64 = mc64 >> 2;
         if (ep >= ec) begin
            x = mp64; ex = ep; sx = prod_ff.sp; y = mc64; ey = ec; sy = sc;
         end else begin
            x = mc64; ex = ec; sx = sc; y = mp64; ey = ep; sy = prod_ff.sp;
         end
         d = ex - ey;
         if (d >= 12'sd63) y = 64'd1;
         else if (d > 0)
            y = (y >> d) | 64'((y & ((64'd1 << d) - 64'd1)) != 0);
         if (sx == sy) begin
            rnd_byp_in = 1'b0;
            rnd_sum_in = x + y; rnd_sx_in = sx; rnd_e_in = ex;
         end else if (x == y) begin
            rnd_byp_bits_in = 32'd0;
         end else begin
            rnd_byp_in = 1'b0;
            rnd_e_in = ex;
            if (x > y) begin
               rnd_sum_in = x - y; rnd_sx_in = sx;
            end else begin
               rnd_sum_in = y - x; rnd_sx_in = sy;
            end
         end
      end
   end

   // round stage: normalize and round
   always_comb begin
      logic [6:0] lz;
      lz = lzc64(rnd_sum_ff);
      if (rnd_byp_ff) fma_res = rnd_byp_bits_ff;
      else fma_res = round_pack(rnd_sx_ff, rnd_sum_ff << lz, rnd_e_ff - 12'(lz));
   end

   assign row_end = ((CW+1)'(col_pos_ff) + (CW+1)'(1)) >= cols_eff;

   // control: next state, positions and accumulator
   always_comb begin
      state_in = state_ff;
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      acc_in = acc_ff;
      emit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.req_type == REQ_MATRIX) begin
               state_in = ST_MUL;
               if (col_pos_ff == '0) acc_in = req_data.seed_bits;
            end
         end
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = ST_DONE;
         ST_DONE: begin
            // a finished row waits here while the previous result is unread
            if (!(row_end && rsp_valid_ff && !rsp_ready)) begin
               state_in = ST_IDLE;
               acc_in = fma_res;
               if (row_end) begin
                  emit = 1'b1;
                  col_pos_in = '0;
                  if ({1'b0, row_pos_ff} + 17'd1 >= {1'b0, rows_eff}) row_pos_in = '0;
                  else row_pos_in = row_pos_ff + 16'd1;
               end else begin
                  col_pos_in = col_pos_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_count_ff <= 16'd1;
         col_count_ff <= 9'd1;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         acc_ff     <= acc_in;
         if (csr_write) begin
            if (csr_index == CSR_ROW_COUNT) row_count_ff <= csr_data;
            else col_count_ff <= csr_data[8:0];
         end
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         elem_ff <= req_data.element_bits;
         oob_ff  <= 1'b0;
      end
      if (state_ff == ST_MUL) prod_ff <= prod_in;
      if (state_ff == ST_ADD) begin
         rnd_sum_ff      <= rnd_sum_in;
         rnd_sx_ff       <= rnd_sx_in;
         rnd_e_ff        <= rnd_e_in;
         rnd_byp_ff      <= rnd_byp_in;
         rnd_byp_bits_ff <= rnd_byp_bits_in;
      end
      if (emit) begin
         rsp_ff.row_number <= row_pos_ff;
         rsp_ff.sum_bits   <= fma_res;
         rsp_ff.last_row   <= ({1'b0, row_pos_ff} + 17'd1 >= {1'b0, rows_eff});
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // result never overwritten while waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !emit)
      else $error("result overwritten");
   // no new transaction while a matrix item is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("accepted while busy");
   // accumulator holds across the multiply stage; it only changes on seed or round stage
   a_acc: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) == ST_MUL |-> $stable(acc_ff))
      else $error("accumulator changed in multiply stage");
`endif

endmodule

// File: hdl/fmva_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmva_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module fmva_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule
